// ----- design/hlsa_pkg.sv -----
// ----------------------------------------------------------------------------
// HSL adjust package
// Shared constants, codes and a small helper for the lightness/saturation
// adjust pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package hlsa_pkg;

	localparam int unsigned PIX_W  = 8;
	localparam int unsigned HUE_W  = 9;
	localparam int unsigned IDX_W  = 8;

	// configuration register indexes
	localparam logic [IDX_W-1:0] CFG_AMOUNT = 8'd0;
	localparam logic [IDX_W-1:0] CFG_TARGET = 8'd1;

	localparam logic TARGET_LIGHT = 1'b0;
	localparam logic TARGET_SAT   = 1'b1;

	// reciprocals: x/100 = (x*RECIP_100)>>22 for x < 43690,
	// x/60 = (x*RECIP_60)>>20 for x < 23831
	localparam logic [15:0] RECIP_100 = 16'd41944;
	localparam int unsigned SHIFT_100 = 22;
	localparam logic [14:0] RECIP_60  = 15'd17477;
	localparam int unsigned SHIFT_60  = 20;

	typedef enum logic [2:0] {
		SEXT_RG = 3'd0,
		SEXT_GR = 3'd1,
		SEXT_GB = 3'd2,
		SEXT_BG = 3'd3,
		SEXT_BR = 3'd4,
		SEXT_RB = 3'd5
	} sext_t;

	// 255 - |2l - 255|
	function automatic logic [PIX_W-1:0] spread(input logic [PIX_W-1:0] l);
		logic [PIX_W-1:0] r;
		if (l[7]) begin
			r = 8'(9'd510 - {l, 1'b0});
		end else begin
			r = {l[6:0], 1'b0};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ----- design/hsl_lightness_saturation_adjust_unit.sv -----
// ----------------------------------------------------------------------------
// HSL lightness / saturation adjust unit
// Converts each RGB pixel to integer HSL, moves lightness or saturation by
// a signed percentage and converts back to RGB.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on in_valid/in_stall with red_in, green_in, blue_in and leave
//   on out_valid/out_stall with red_out, green_out, blue_out. A transfer
//   happens on a rising edge with valid high and stall low.
//   An input transfer reaches out_valid through the nine pipeline stages;
//   one pixel is taken every cycle while the output is not stalled. The
//   pipeline's two dividers are unrolled restoring dividers spread over
//   stages two to four.
//   A stall on the output with a valid result holds the whole pipeline and
//   raises in_stall in the same cycle; nothing is lost or repeated.
//   Registers (cfg_valid/cfg_ready, always ready): index 0 is the signed
//   amount (-100..100, zero gives pass-through), index 1 selects lightness
//   (0) or saturation (1). Write them only while the pipeline is empty.
//   Reset clears all valid bits and both registers.
// ----------------------------------------------------------------------------
`default_nettype none

module hsl_lightness_saturation_adjust_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire logic [hlsa_pkg::PIX_W-1:0]  red_in,
	input  wire logic [hlsa_pkg::PIX_W-1:0]  green_in,
	input  wire logic [hlsa_pkg::PIX_W-1:0]  blue_in,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output logic [hlsa_pkg::PIX_W-1:0]       red_out,
	output logic [hlsa_pkg::PIX_W-1:0]       green_out,
	output logic [hlsa_pkg::PIX_W-1:0]       blue_out,
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [hlsa_pkg::IDX_W-1:0]  cfg_index,
	input  wire logic [7:0]                  cfg_data
);
	import hlsa_pkg::*;

	logic signed [7:0] amount_q;
	logic              target_q;
	logic              adv;
	logic [8:0]        v_q;

	// pixel carried for pass-through
	logic [23:0] rgb_s1, rgb_s2, rgb_s3, rgb_s4, rgb_s5, rgb_s6, rgb_s7, rgb_s8;

	// stage 1
	logic [7:0] r_s1, d_s1, l_s1;
	logic       grey_s1, neg_s1;
	logic [8:0] base_s1;
	// stage 2/3
	logic [13:0] rem1_s2, rem1_s3;
	logic [5:0]  q1_s2, q1_s3;
	logic [15:0] rem2_s2, rem2_s3;
	logic [7:0]  q2_s2, q2_s3;
	logic [7:0]  r_s2, r_s3, sp_s2, sp_s3, l_s2, l_s3;
	logic        over_s2, over_s3, grey_s2, grey_s3, neg_s2, neg_s3;
	logic [8:0]  base_s2, base_s3;
	// stage 4..9
	logic [8:0]  h_s4, h_s5, h_s6, h_s7;
	logic [7:0]  l_s4, s_s4, l_s5, s_s5, p_s5, l_s6, s_s6, l_s7;
	logic [15:0] x_s5, prod_s7;
	logic        pos_s5, kill_s5;
	logic [7:0]  lo_s8, span_s8;
	logic [13:0] pk_s8;
	sext_t       sext_s8;
	logic [7:0]  red_s9, green_s9, blue_s9;

	assign adv       = !(v_q[8] && out_stall);
	assign in_stall  = !adv;
	assign cfg_ready = 1'b1;
	assign out_valid = v_q[8];
	assign red_out   = red_s9;
	assign green_out = green_s9;
	assign blue_out  = blue_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			amount_q <= '0;
			target_q <= TARGET_LIGHT;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_AMOUNT) begin
				amount_q <= cfg_data;
			end else if (cfg_index == CFG_TARGET) begin
				target_q <= cfg_data[0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (adv) begin
			v_q <= {v_q[7:0], in_valid};
		end
	end

	// ---- stage 1: sort channels, sextant base, lightness
	logic [7:0] mx_c, md_c, mn_c;
	logic [8:0] base_c;
	logic       neg_c;
	logic [8:0] sum_c;

	always_comb begin
		if (red_in >= green_in && green_in >= blue_in) begin
			mx_c = red_in;   md_c = green_in; mn_c = blue_in;  base_c = 9'd0;   neg_c = 1'b0;
		end else if (green_in > red_in && red_in >= blue_in) begin
			mx_c = green_in; md_c = red_in;   mn_c = blue_in;  base_c = 9'd120; neg_c = 1'b1;
		end else if (green_in >= blue_in && blue_in > red_in) begin
			mx_c = green_in; md_c = blue_in;  mn_c = red_in;   base_c = 9'd120; neg_c = 1'b0;
		end else if (blue_in > green_in && green_in > red_in) begin
			mx_c = blue_in;  md_c = green_in; mn_c = red_in;   base_c = 9'd240; neg_c = 1'b1;
		end else if (blue_in >= red_in && red_in >= green_in) begin
			mx_c = blue_in;  md_c = red_in;   mn_c = green_in; base_c = 9'd240; neg_c = 1'b0;
		end else begin
			mx_c = red_in;   md_c = blue_in;  mn_c = green_in; base_c = 9'd360; neg_c = 1'b1;
		end
		sum_c = {1'b0, mx_c} + {1'b0, mn_c};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s1  <= {red_in, green_in, blue_in};
			r_s1    <= mx_c - mn_c;
			d_s1    <= md_c - mn_c;
			l_s1    <= sum_c[8:1];
			grey_s1 <= (mx_c == mn_c);
			base_s1 <= base_c;
			neg_s1  <= neg_c;
		end
	end

	// ---- stage 2: dividend set-up, hue quotient bits 5..4, saturation bits 7..6
	logic [13:0] n1_c, rem1_c2;
	logic [15:0] n2_c, rem2_c2;
	logic [7:0]  sp_c;
	logic [5:0]  q1_c2;
	logic [7:0]  q2_c2;

	always_comb begin
		n1_c  = 14'(d_s1) * 14'd60;
		n2_c  = 16'(r_s1) * 16'd255;
		sp_c  = spread(l_s1);
		rem1_c2 = n1_c;
		q1_c2   = '0;
		for (int i = 5; i >= 4; i--) begin
			if (rem1_c2 >= (14'(r_s1) << i)) begin
				rem1_c2  = rem1_c2 - (14'(r_s1) << i);
				q1_c2[i] = 1'b1;
			end
		end
		rem2_c2 = n2_c;
		q2_c2   = '0;
		for (int i = 7; i >= 6; i--) begin
			if (rem2_c2 >= (16'(sp_c) << i)) begin
				rem2_c2  = rem2_c2 - (16'(sp_c) << i);
				q2_c2[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s2  <= rgb_s1;
			rem1_s2 <= rem1_c2;
			q1_s2   <= q1_c2;
			rem2_s2 <= rem2_c2;
			q2_s2   <= q2_c2;
			over_s2 <= (n2_c[15:8] >= sp_c);
			r_s2    <= r_s1;
			sp_s2   <= sp_c;
			l_s2    <= l_s1;
			grey_s2 <= grey_s1;
			base_s2 <= base_s1;
			neg_s2  <= neg_s1;
		end
	end

	// ---- stage 3: hue bits 3..1, saturation bits 5..3
	logic [13:0] rem1_c3;
	logic [15:0] rem2_c3;
	logic [5:0]  q1_c3;
	logic [7:0]  q2_c3;

	always_comb begin
		rem1_c3 = rem1_s2;
		q1_c3   = q1_s2;
		for (int i = 3; i >= 1; i--) begin
			if (rem1_c3 >= (14'(r_s2) << i)) begin
				rem1_c3  = rem1_c3 - (14'(r_s2) << i);
				q1_c3[i] = 1'b1;
			end
		end
		rem2_c3 = rem2_s2;
		q2_c3   = q2_s2;
		for (int i = 5; i >= 3; i--) begin
			if (rem2_c3 >= (16'(sp_s2) << i)) begin
				rem2_c3  = rem2_c3 - (16'(sp_s2) << i);
				q2_c3[i] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s3  <= rgb_s2;
			rem1_s3 <= rem1_c3;
			q1_s3   <= q1_c3;
			rem2_s3 <= rem2_c3;
			q2_s3   <= q2_c3;
			over_s3 <= over_s2;
			r_s3    <= r_s2;
			sp_s3   <= sp_s2;
			l_s3    <= l_s2;
			grey_s3 <= grey_s2;
			base_s3 <= base_s2;
			neg_s3  <= neg_s2;
		end
	end

	// ---- stage 4: last quotient bits, hue and saturation
	logic [15:0] rem2_c4;
	logic [5:0]  q1_c4;
	logic [7:0]  q2_c4;
	logic [8:0]  h_c;
	logic [7:0]  s_c;

	always_comb begin
		q1_c4 = q1_s3;
		if (rem1_s3 >= 14'(r_s3)) begin
			q1_c4[0] = 1'b1;
		end
		rem2_c4 = rem2_s3;
		q2_c4   = q2_s3;
		for (int i = 2; i >= 0; i--) begin
			if (rem2_c4 >= (16'(sp_s3) << i)) begin
				rem2_c4  = rem2_c4 - (16'(sp_s3) << i);
				q2_c4[i] = 1'b1;
			end
		end
		if (grey_s3) begin
			h_c = '0;
		end else if (neg_s3) begin
			h_c = base_s3 - 9'(q1_c4);
		end else begin
			h_c = base_s3 + 9'(q1_c4);
		end
		if (grey_s3 || l_s3 == 8'd0) begin
			s_c = '0;
		end else if (over_s3) begin
			s_c = 8'd255;
		end else begin
			s_c = q2_c4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s4 <= rgb_s3;
			h_s4   <= h_c;
			l_s4   <= l_s3;
			s_s4   <= s_c;
		end
	end

	// ---- stage 5: percentage product
	logic [7:0]        p_c;
	logic signed [8:0] f_c;
	logic              pos_c;

	always_comb begin
		p_c   = (target_q == TARGET_SAT) ? s_s4 : l_s4;
		pos_c = (amount_q > 8'sd0);
		f_c   = 9'sd100 + 9'(amount_q);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s5  <= rgb_s4;
			h_s5    <= h_s4;
			l_s5    <= l_s4;
			s_s5    <= s_s4;
			p_s5    <= p_c;
			pos_s5  <= pos_c;
			kill_s5 <= !pos_c && (f_c <= 9'sd0);
			if (pos_c) begin
				x_s5 <= 16'(8'd255 - p_c) * 16'(amount_q[6:0]);
			end else begin
				x_s5 <= 16'(p_c) * 16'(f_c[7:0]);
			end
		end
	end

	// ---- stage 6: divide by 100 and clamp
	logic [31:0] qm_c;
	logic [9:0]  sum6_c;
	logic [7:0]  res_c;

	always_comb begin
		qm_c   = 32'(x_s5) * 32'(RECIP_100);
		sum6_c = 10'(p_s5) + 10'(qm_c[31:SHIFT_100]);
		if (pos_s5) begin
			res_c = (sum6_c > 10'd255) ? 8'd255 : sum6_c[7:0];
		end else if (kill_s5) begin
			res_c = '0;
		end else begin
			res_c = 8'(qm_c[31:SHIFT_100]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s6 <= rgb_s5;
			h_s6   <= h_s5;
			l_s6   <= (target_q == TARGET_LIGHT) ? res_c : l_s5;
			s_s6   <= (target_q == TARGET_SAT) ? res_c : s_s5;
		end
	end

	// ---- stage 7: saturation times spread
	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s7  <= rgb_s6;
			h_s7    <= h_s6;
			l_s7    <= l_s6;
			prod_s7 <= 16'(s_s6) * 16'(spread(l_s6));
		end
	end

	// ---- stage 8: span, low channel, sextant distance
	logic [16:0] d255_c;
	logic [7:0]  span_c;
	logic [8:0]  half_c;
	logic [5:0]  k_c;
	sext_t       sext_c;

	always_comb begin
		d255_c = 17'(prod_s7) + 17'(prod_s7[15:8]) + 17'd1;
		span_c = d255_c[15:8];
		half_c = (9'(span_c) + 9'd1) >> 1;
		if (h_s7 < 9'd60) begin
			sext_c = SEXT_RG; k_c = 6'(h_s7);
		end else if (h_s7 < 9'd120) begin
			sext_c = SEXT_GR; k_c = 6'(9'd120 - h_s7);
		end else if (h_s7 < 9'd180) begin
			sext_c = SEXT_GB; k_c = 6'(h_s7 - 9'd120);
		end else if (h_s7 < 9'd240) begin
			sext_c = SEXT_BG; k_c = 6'(9'd240 - h_s7);
		end else if (h_s7 < 9'd300) begin
			sext_c = SEXT_BR; k_c = 6'(h_s7 - 9'd240);
		end else begin
			sext_c = SEXT_RB; k_c = 6'(9'd360 - h_s7);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rgb_s8  <= rgb_s7;
			span_s8 <= span_c;
			lo_s8   <= 8'(9'(l_s7) - half_c);
			pk_s8   <= 14'(span_c) * 14'(k_c);
			sext_s8 <= sext_c;
		end
	end

	// ---- stage 9: rebuild channels
	logic [28:0] mq_c;
	logic [8:0]  top_w, mid_w;
	logic [7:0]  top_c, mid_c, bot_c;

	always_comb begin
		mq_c  = 29'(pk_s8) * 29'(RECIP_60);
		top_w = 9'(lo_s8) + 9'(span_s8);
		mid_w = 9'(lo_s8) + 9'(mq_c[28:SHIFT_60]);
		top_c = top_w[8] ? 8'd255 : top_w[7:0];
		mid_c = mid_w[8] ? 8'd255 : mid_w[7:0];
		bot_c = lo_s8;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (amount_q == 8'sd0) begin
				{red_s9, green_s9, blue_s9} <= rgb_s8;
			end else begin
				case (sext_s8)
					SEXT_RG: begin red_s9 <= top_c; green_s9 <= mid_c; blue_s9 <= bot_c; end
					SEXT_GR: begin red_s9 <= mid_c; green_s9 <= top_c; blue_s9 <= bot_c; end
					SEXT_GB: begin red_s9 <= bot_c; green_s9 <= top_c; blue_s9 <= mid_c; end
					SEXT_BG: begin red_s9 <= bot_c; green_s9 <= mid_c; blue_s9 <= top_c; end
					SEXT_BR: begin red_s9 <= mid_c; green_s9 <= bot_c; blue_s9 <= top_c; end
					default: begin red_s9 <= top_c; green_s9 <= bot_c; blue_s9 <= mid_c; end
				endcase
			end
		end
	end

endmodule

`default_nettype wire
